// ===== sv/assert_macros.svh =====
// assertion helpers included by the rtl files that use them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of aclk outside reset
`define ASSERT_CLK(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== sv/pss_pkg.sv =====
`timescale 1ns / 1ps

package pss_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int DAMP_BITS   = 16;
    localparam int LEN_CFG_W   = 11;
    localparam int LFSR_W      = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

    // drum sign is kept when (v*100)>>16 > 50, i.e. v >= ceil(51*65536/100)
    localparam int DRUM_KEEP_MIN_INT = (51 * 65536 + 99) / 100;
    localparam logic [15:0] DRUM_KEEP_MIN = 16'(DRUM_KEEP_MIN_INT);

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED   = 2'd2;

    localparam logic [LEN_CFG_W-1:0] DELAY_LENGTH_RST = 11'd100;
    localparam logic [DAMP_BITS-1:0] DAMPING_RST      = 16'd65208;
    localparam logic [LFSR_W-1:0]    NOISE_SEED_RST   = 32'd1;

    // operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        ALU_PASS  = 2'd0,
        ALU_AVG   = 2'd1,
        ALU_SCALE = 2'd2,
        ALU_NEG   = 2'd3
    } alu_op_t;

    typedef struct packed {
        alu_op_t                op;
        logic [DAMP_BITS-1:0]   gain;
    } alu_ctrl_t;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] x);
        logic [LFSR_W-1:0] y;
        y = {1'b0, x[LFSR_W-1:1]};
        if (x[0]) begin
            y = y ^ LFSR_TAPS;
        end
        return y;
    endfunction

endpackage

// ===== sv/plucked_string_synth.sv =====
`timescale 1ns / 1ps
// plucked string synthesizer on a circular delay memory
// input channel (s_*): one transaction per command; s_command = 0 is a sample
//   tick, 1 is a pluck that refills the active delay entries with lfsr noise
// output channel (m_*): one transaction with m_sample_out per tick, none per pluck
// config port: cfg_wr_en/cfg_index/cfg_data write delay_length (0), damping (1)
//   and noise_seed (2, also loads the lfsr at once); write only while idle
// tick: accepted, then read next entry, average, damping multiply, and drum sign
//   and write-back in turn through one shared arithmetic unit; the last step also
//   loads the current entry into the output register; the steps are sequenced
//   by the single read port of the delay memory and the shared unit
// pluck: one memory write per cycle until every active entry is filled
// reset: the memory is swept to zero with s_ready low;
//   position 0, delay_length 100, damping 65208, lfsr 1
// stall: a result waiting in the output register does not block accepting the
//   next command; a tick only waits in its final step until that register
//   has been taken

module plucked_string_synth #(
    parameter int MAX_LENGTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_command,
    input  logic                                   s_drum_mode,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [pss_pkg::SAMPLE_BITS-1:0] m_sample_out,
    input  logic                                   cfg_wr_en,
    input  logic [pss_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]         cfg_data
);

`include "assert_macros.svh"

    localparam int SW    = pss_pkg::SAMPLE_BITS;
    localparam int PTR_W = $clog2(MAX_LENGTH);
    localparam int LEN_W = $clog2(MAX_LENGTH + 1);

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_RDNXT = 3'd3;
    localparam logic [2:0] ST_AVG   = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0]                        state_reg, state_next;
    logic [LEN_W-1:0]                  cnt_reg, cnt_next;
    logic [LEN_W-1:0]                  len_reg, len_next;
    logic [PTR_W-1:0]                  pos_reg, pos_next;
    logic [PTR_W-1:0]                  nidx_reg, nidx_next;
    logic                              drum_reg, drum_next;
    logic [pss_pkg::LFSR_W-1:0]        lfsr_reg, lfsr_next;
    logic [pss_pkg::LEN_CFG_W-1:0]     delay_length_reg, delay_length_next;
    logic [pss_pkg::DAMP_BITS-1:0]     damping_reg, damping_next;
    logic signed [SW-1:0]              cur_reg, cur_next;
    logic signed [SW-1:0]              acc_reg, acc_next;
    logic                              m_valid_reg, m_valid_next;
    logic signed [SW-1:0]              m_sample_reg, m_sample_next;

    // delay memory, one write and one registered read per cycle
    logic signed [SW-1:0]              mem [MAX_LENGTH];
    logic signed [SW-1:0]              rd_data_reg;
    logic [PTR_W-1:0]                  rd_addr;
    logic                              wr_en;
    logic [PTR_W-1:0]                  wr_addr;
    logic signed [SW-1:0]              wr_data;

    logic [pss_pkg::LFSR_W-1:0]        lfsr_adv;
    logic [LEN_W-1:0]                  pos_inc;
    logic                              out_free;
    logic                              in_acc;
    logic                              flip;

    pss_pkg::alu_ctrl_t                alu_ctrl;
    logic signed [SW-1:0]              alu_a;
    logic signed [SW-1:0]              alu_y;

    assign s_ready      = (state_reg == ST_IDLE);
    assign in_acc       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign out_free     = !m_valid_reg || m_ready;
    assign lfsr_adv     = pss_pkg::lfsr_step(lfsr_reg);
    // drum draw: low 16 bits of the advanced lfsr pick the sign
    assign flip         = drum_reg && (lfsr_adv[15:0] < pss_pkg::DRUM_KEEP_MIN);

    // shared unit: average in ST_AVG, damping in ST_MUL, negate in ST_FIN
    always_comb begin
        alu_ctrl.gain = damping_reg;
        alu_a         = acc_reg;
        priority if (state_reg == ST_AVG) begin
            alu_ctrl.op = pss_pkg::ALU_AVG;
            alu_a       = cur_reg;
        end else if (state_reg == ST_MUL) begin
            alu_ctrl.op = pss_pkg::ALU_SCALE;
        end else if (state_reg == ST_FIN) begin
            alu_ctrl.op = pss_pkg::ALU_NEG;
        end else begin
            alu_ctrl.op = pss_pkg::ALU_PASS;
        end
    end

    pss_alu u_alu (
        .ctrl (alu_ctrl),
        .a    (alu_a),
        .b    (rd_data_reg),
        .y    (alu_y)
    );

    // length clamp and next position, taken at accept time
    always_comb begin
        if (delay_length_reg < pss_pkg::LEN_CFG_W'(2)) begin
            len_next = LEN_W'(2);
        end else if (32'(delay_length_reg) > 32'(MAX_LENGTH)) begin
            len_next = LEN_W'(MAX_LENGTH);
        end else begin
            len_next = LEN_W'(delay_length_reg);
        end
        pos_inc = LEN_W'(pos_reg) + LEN_W'(1);
    end

    always_comb begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        pos_next          = pos_reg;
        nidx_next         = nidx_reg;
        drum_next         = drum_reg;
        lfsr_next         = lfsr_reg;
        delay_length_next = delay_length_reg;
        damping_next      = damping_reg;
        cur_next          = cur_reg;
        acc_next          = acc_reg;
        m_valid_next      = m_valid_reg;
        m_sample_next     = m_sample_reg;
        rd_addr           = pos_reg;
        wr_en             = 1'b0;
        wr_addr           = pos_reg;
        wr_data           = acc_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[PTR_W-1:0];
                wr_data = '0;
                if (cnt_reg == LEN_W'(MAX_LENGTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + LEN_W'(1);
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    drum_next = s_drum_mode;
                    cnt_next  = '0;
                    if (s_command) begin
                        state_next = ST_FILL;
                    end else begin
                        nidx_next  = (pos_inc >= len_next) ? '0 : pos_inc[PTR_W-1:0];
                        state_next = ST_RDNXT;
                    end
                end
            end
            ST_FILL: begin
                lfsr_next = lfsr_adv;
                wr_en     = 1'b1;
                wr_addr   = cnt_reg[PTR_W-1:0];
                wr_data   = lfsr_adv[SW-1:0];
                if (cnt_reg == len_reg - LEN_W'(1)) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + LEN_W'(1);
                end
            end
            ST_RDNXT: begin
                cur_next   = rd_data_reg;
                rd_addr    = nidx_reg;
                state_next = ST_AVG;
            end
            ST_AVG: begin
                acc_next   = alu_y;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                acc_next   = alu_y;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    if (drum_reg) begin
                        lfsr_next = lfsr_adv;
                    end
                    wr_en         = 1'b1;
                    wr_data       = flip ? alu_y : acc_reg;
                    pos_next      = nidx_reg;
                    m_valid_next  = 1'b1;
                    m_sample_next = cur_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            unique case (cfg_index)
                pss_pkg::REG_DELAY_LENGTH:
                    delay_length_next = cfg_data[pss_pkg::LEN_CFG_W-1:0];
                pss_pkg::REG_DAMPING:
                    damping_next = cfg_data[pss_pkg::DAMP_BITS-1:0];
                pss_pkg::REG_NOISE_SEED:
                    // an all-zero seed would lock the lfsr
                    lfsr_next = (cfg_data == '0) ? pss_pkg::LFSR_W'(1) : cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            cnt_reg          <= '0;
            pos_reg          <= '0;
            lfsr_reg         <= pss_pkg::NOISE_SEED_RST;
            delay_length_reg <= pss_pkg::DELAY_LENGTH_RST;
            damping_reg      <= pss_pkg::DAMPING_RST;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            pos_reg          <= pos_next;
            lfsr_reg         <= lfsr_next;
            delay_length_reg <= delay_length_next;
            damping_reg      <= damping_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            len_reg <= len_next;
        end
        nidx_reg     <= nidx_next;
        drum_reg     <= drum_next;
        cur_reg      <= cur_next;
        acc_reg      <= acc_next;
        m_sample_reg <= m_sample_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    `ASSERT_NEVER(a_pos_in_range, 32'(pos_reg) >= 32'(MAX_LENGTH))
    `ASSERT_CLK(a_tick_starts, (in_acc && !s_command) |=> (state_reg == ST_RDNXT))
    `ASSERT_CLK(a_result_from_fin, $rose(m_valid_reg) |-> ($past(state_reg) == ST_FIN))
    `ASSERT_CLK(a_fill_bounded, (state_reg == ST_FILL) |-> (cnt_reg < len_reg))

endmodule

// ===== sv/pss_alu.sv =====
`timescale 1ns / 1ps

module pss_alu (
    input  pss_pkg::alu_ctrl_t                    ctrl,
    input  logic signed [pss_pkg::SAMPLE_BITS-1:0] a,
    input  logic signed [pss_pkg::SAMPLE_BITS-1:0] b,
    output logic signed [pss_pkg::SAMPLE_BITS-1:0] y
);

    localparam int SW = pss_pkg::SAMPLE_BITS;
    localparam int PW = SW + pss_pkg::DAMP_BITS + 1;

    logic signed [SW:0]   sum;
    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] smin;
    logic signed [SW-1:0] smax;

    assign smin = {1'b1, {(SW-1){1'b0}}};
    assign smax = {1'b0, {(SW-1){1'b1}}};

    // floor((a+b)/2): drop the low bit of the widened sum
    assign sum  = (SW+1)'(a) + (SW+1)'(b);
    // signed sample times unsigned Q0.16 gain
    assign prod = PW'(a) * $signed({1'b0, ctrl.gain});

    always_comb begin
        unique case (ctrl.op)
            pss_pkg::ALU_AVG:   y = sum[SW:1];
            pss_pkg::ALU_SCALE: y = prod[SW+pss_pkg::DAMP_BITS-1:pss_pkg::DAMP_BITS];
            pss_pkg::ALU_NEG:   y = (a == smin) ? smax : -a;
            default:            y = a;
        endcase
    end

endmodule
